### sv/encoder_position_speed_estimator_assert.svh
// Assertion macros shared by the checker.
// Both macros sample on aclk and are disabled while aresetn is low.
`ifndef ENCODER_POSITION_SPEED_ESTIMATOR_ASSERT_SVH
`define ENCODER_POSITION_SPEED_ESTIMATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EPSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/epse_pkg.sv
`timescale 1ns / 1ps

package epse_pkg;

    localparam int MOTOR_COUNT = 2;
    localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    // item kinds
    localparam logic [1:0] KIND_POS   = 2'd0;
    localparam logic [1:0] KIND_SPEED = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // config register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_MASK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNTS_PER_REV = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_INTERVAL = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA = 2'd3;

    // config reset values
    localparam logic [1:0]  RST_REVERSE_MASK   = 2'd1;
    localparam logic [15:0] RST_COUNTS_PER_REV = 16'd3960;
    localparam logic [15:0] RST_MIN_INTERVAL   = 16'd250;
    localparam logic [16:0] RST_ALPHA          = 17'd13107;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic signed [6:0] S_PER_MIN = 7'sd60;

    // restoring divider: 31 quotient bits below the saturation point
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_USED_W  = 65;
    localparam int M_TDATA_W = 72;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_CHK,
        S_MUL,
        S_DCHK,
        S_DIV,
        S_EMA_MUL,
        S_EMA_ADD,
        S_SCALE,
        S_OUT
    } epse_state_t;

    typedef struct packed {
        logic load_in;
        logic upd;
        logic chk;
        logic mul;
        logic dchk;
        logic div_step;
        logic ema_mul;
        logic ema_add;
        logic scale;
        logic load_out;
    } epse_cmd_t;

    typedef struct packed {
        logic short_path;  // result final after the position update
        logic no_update;   // speed estimate left as is
        logic div_skip;    // quotient known without dividing
        logic div_last;
    } epse_status_t;

endpackage

### sv/encoder_position_speed_estimator.sv
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// s_       | s_tvalid / s_tready       | s_tdata: kind, motor_number, raw_count, now_us
// m_       | m_tvalid / m_tready       | m_tdata: motor_ok, position, speed_rpm
// cfg_     | cfg_wr_en (no wait)       | cfg_addr, cfg_wr_data
// One item at a time: an invalid motor, position read, clear or first speed read ends
// after the position update; a non-updating speed read adds check and scale; an update
// adds the 31-step restoring divider, which zero cpr, zero dt or saturation skip.
// aresetn (synchronous) clears control, motor state and config to reset values.
// A finished result waits in the output register; the next item is taken meanwhile
// and holds in its last state until that register frees.

module encoder_position_speed_estimator import epse_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] kind, [3:2] motor_number, [19:4] raw_count, [51:20] now_us
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] motor_ok, [32:1] position, [64:33] speed_rpm
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    epse_cmd_t    cmd;
    epse_status_t status;
    logic         out_motor_ok;
    logic [31:0]  out_position;
    logic [31:0]  out_speed_rpm;

    epse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epse_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_kind         (s_tdata[1:0]),
        .in_motor_number (s_tdata[3:2]),
        .in_raw_count    (s_tdata[19:4]),
        .in_now_us       (s_tdata[51:20]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .out_motor_ok    (out_motor_ok),
        .out_position    (out_position),
        .out_speed_rpm   (out_speed_rpm)
    );

    assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, out_speed_rpm, out_position,
                      out_motor_ok};

endmodule

### sv/epse_ctrl.sv
`timescale 1ns / 1ps

module epse_ctrl import epse_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  epse_status_t status,
    output epse_cmd_t    cmd
);

    epse_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_UPD;
            S_UPD:     state_next = status.short_path ? S_OUT : S_CHK;
            S_CHK:     state_next = status.no_update ? S_SCALE : S_MUL;
            S_MUL:     state_next = S_DCHK;
            S_DCHK:    state_next = status.div_skip ? S_EMA_MUL : S_DIV;
            S_DIV:     if (status.div_last) state_next = S_EMA_MUL;
            S_EMA_MUL: state_next = S_EMA_ADD;
            S_EMA_ADD: state_next = S_SCALE;
            S_SCALE:   state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:    cmd.load_in = s_tvalid;
            S_UPD:     cmd.upd = 1'b1;
            S_CHK:     cmd.chk = 1'b1;
            S_MUL:     cmd.mul = 1'b1;
            S_DCHK:    cmd.dchk = 1'b1;
            S_DIV:     cmd.div_step = 1'b1;
            S_EMA_MUL: cmd.ema_mul = 1'b1;
            S_EMA_ADD: cmd.ema_add = 1'b1;
            S_SCALE:   cmd.scale = 1'b1;
            S_OUT:     cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### sv/epse_dp.sv
`timescale 1ns / 1ps

module epse_dp import epse_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            in_kind,
    input  logic [1:0]            in_motor_number,
    input  logic [15:0]           in_raw_count,
    input  logic [31:0]           in_now_us,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  epse_cmd_t             cmd,
    output epse_status_t          status,
    output logic                  out_motor_ok,
    output logic [31:0]           out_position,
    output logic [31:0]           out_speed_rpm
);

    // configuration
    logic [1:0]  reverse_mask_reg;
    logic [15:0] cpr_reg;
    logic [15:0] min_interval_reg;
    logic [16:0] alpha_reg;

    // per-motor state
    logic [15:0] last_raw_reg   [MOTOR_COUNT];
    logic [31:0] pos_reg        [MOTOR_COUNT];
    logic [31:0] base_cnt_reg   [MOTOR_COUNT];
    logic [31:0] base_time_reg  [MOTOR_COUNT];
    logic [31:0] rps_reg        [MOTOR_COUNT];
    logic        primed_reg     [MOTOR_COUNT];

    // current item
    logic [1:0]  kind_reg;
    logic [1:0]  motor_reg;
    logic [15:0] raw_reg;
    logic [31:0] now_reg;

    // work registers
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic [31:0] dt_reg;
    logic [51:0] num_reg;
    logic [47:0] den_reg;
    logic [47:0] rem_reg;
    logic [30:0] low_reg;
    logic [30:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [50:0] prod_reg;

    logic        res_ok_reg;
    logic [31:0] res_pos_reg;
    logic [31:0] res_rpm_reg;
    logic        out_ok_reg;
    logic [31:0] out_pos_reg;
    logic [31:0] out_rpm_reg;

    logic [1:0]        idx_full;
    logic [MIDX_W-1:0] idx;
    logic              item_valid;
    logic              reversed;
    logic [15:0]       raw_diff;
    logic [31:0]       delta_ext;
    logic [31:0]       delta_dir;
    logic [31:0]       new_pos;
    logic [31:0]       dt;
    logic [31:0]       dd;
    logic [31:0]       dd_mag;
    logic [36:0]       div_hi;
    logic [48:0]       trial;
    logic              fits;
    logic [48:0]       rem_after;
    logic [32:0]       quo_ext;
    logic signed [32:0] n_s;
    logic signed [32:0] s_s;
    logic signed [32:0] diff_s;
    logic [16:0]       alpha_eff;
    logic signed [17:0] alpha_s;
    logic [34:0]       step;
    logic [31:0]       rps_new;
    logic signed [37:0] scaled;
    logic [31:0]       rpm_sat;

    assign idx_full   = motor_reg - 2'd1;
    assign idx        = idx_full[MIDX_W-1:0];
    assign item_valid = (motor_reg != 2'd0) && (int'(motor_reg) <= MOTOR_COUNT)
                        && (kind_reg != KIND_RSVD);
    // only the first two motors have a direction bit
    assign reversed   = !idx_full[1] && reverse_mask_reg[idx_full[0]];

    assign raw_diff  = raw_reg - last_raw_reg[idx];
    assign delta_ext = {{16{raw_diff[15]}}, raw_diff};
    assign delta_dir = reversed ? (32'd0 - delta_ext) : delta_ext;
    assign new_pos   = pos_reg[idx] + delta_dir;

    assign dt     = now_reg - base_time_reg[idx];
    assign dd     = pos_reg[idx] - base_cnt_reg[idx];
    assign dd_mag = dd[31] ? (32'd0 - dd) : dd;

    // quotient of num*2^16/den saturates once num*2^16 >= den*2^31
    assign div_hi    = num_reg[51:15];
    assign trial     = {rem_reg, low_reg[30]};
    assign fits      = trial >= {1'b0, den_reg};
    assign rem_after = fits ? (trial - {1'b0, den_reg}) : trial;

    assign quo_ext   = {2'b00, quo_reg};
    assign n_s       = neg_reg ? $signed(33'd0 - quo_ext) : $signed(quo_ext);
    assign s_s       = $signed({rps_reg[idx][31], rps_reg[idx]});
    assign diff_s    = n_s - s_s;
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_s   = $signed({1'b0, alpha_eff});

    // arithmetic shift gives floor for both signs
    assign step    = prod_reg[50:16];
    assign rps_new = rps_reg[idx] + step[31:0];

    assign scaled  = 38'(s_s) * 38'(S_PER_MIN);
    always_comb begin
        if (scaled[37:31] == 7'h00 || scaled[37:31] == 7'h7F) begin
            rpm_sat = scaled[31:0];
        end else if (scaled[37]) begin
            rpm_sat = 32'h8000_0000;
        end else begin
            rpm_sat = 32'h7FFF_FFFF;
        end
    end

    assign status.short_path = !item_valid || (kind_reg != KIND_SPEED) || !primed_reg[idx];
    assign status.no_update  = (dt < {16'd0, min_interval_reg}) || (dd == 32'd0);
    assign status.div_skip   = (cpr_reg == 16'd0) || (dt_reg == 32'd0)
                               || ({11'd0, div_hi} >= den_reg);
    assign status.div_last   = (cnt_reg == '0);

    // configuration and motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_mask_reg <= RST_REVERSE_MASK;
            cpr_reg          <= RST_COUNTS_PER_REV;
            min_interval_reg <= RST_MIN_INTERVAL;
            alpha_reg        <= RST_ALPHA;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                last_raw_reg[i]  <= '0;
                pos_reg[i]       <= '0;
                base_cnt_reg[i]  <= '0;
                base_time_reg[i] <= '0;
                rps_reg[i]       <= '0;
                primed_reg[i]    <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_REVERSE_MASK:   reverse_mask_reg <= cfg_wr_data[1:0];
                    CFG_COUNTS_PER_REV: cpr_reg          <= cfg_wr_data[15:0];
                    CFG_MIN_INTERVAL:   min_interval_reg <= cfg_wr_data[15:0];
                    CFG_ALPHA:          alpha_reg        <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.upd && item_valid) begin
                last_raw_reg[idx] <= raw_reg;
                if (kind_reg == KIND_CLEAR) begin
                    pos_reg[idx]       <= '0;
                    base_cnt_reg[idx]  <= '0;
                    base_time_reg[idx] <= '0;
                    rps_reg[idx]       <= '0;
                    primed_reg[idx]    <= 1'b0;
                end else begin
                    pos_reg[idx] <= new_pos;
                    if (kind_reg == KIND_SPEED && !primed_reg[idx]) begin
                        primed_reg[idx]    <= 1'b1;
                        base_time_reg[idx] <= now_reg;
                        base_cnt_reg[idx]  <= new_pos;
                        rps_reg[idx]       <= '0;
                    end
                end
            end
            if (cmd.chk && !status.no_update) begin
                base_cnt_reg[idx]  <= pos_reg[idx];
                base_time_reg[idx] <= now_reg;
            end
            if (cmd.ema_add) begin
                rps_reg[idx] <= rps_new;
            end
        end
    end

    // payload and arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg  <= in_kind;
            motor_reg <= in_motor_number;
            raw_reg   <= in_raw_count;
            now_reg   <= in_now_us;
        end
        if (cmd.upd) begin
            res_ok_reg  <= item_valid;
            res_pos_reg <= (item_valid && kind_reg != KIND_CLEAR) ? new_pos : 32'd0;
            res_rpm_reg <= 32'd0;
        end
        if (cmd.chk) begin
            neg_reg <= dd[31];
            mag_reg <= dd_mag;
            dt_reg  <= dt;
        end
        if (cmd.mul) begin
            num_reg <= 52'(mag_reg) * 52'(US_PER_S);
            den_reg <= 48'(dt_reg) * 48'(cpr_reg);
        end
        if (cmd.dchk) begin
            rem_reg <= {11'd0, div_hi};
            low_reg <= {num_reg[14:0], 16'd0};
            cnt_reg <= CNT_W'(DIV_STEPS - 1);
            if (cpr_reg == 16'd0) begin
                quo_reg <= '0;
            end else if (status.div_skip) begin
                quo_reg <= '1;
            end else begin
                quo_reg <= '0;
            end
        end
        if (cmd.div_step) begin
            rem_reg <= rem_after[47:0];
            low_reg <= {low_reg[29:0], 1'b0};
            quo_reg <= {quo_reg[29:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.ema_mul) begin
            prod_reg <= 51'(diff_s) * 51'(alpha_s);
        end
        if (cmd.scale) begin
            res_rpm_reg <= rpm_sat;
        end
        if (cmd.load_out) begin
            out_ok_reg  <= res_ok_reg;
            out_pos_reg <= res_pos_reg;
            out_rpm_reg <= res_rpm_reg;
        end
    end

    assign out_motor_ok  = out_ok_reg;
    assign out_position  = out_pos_reg;
    assign out_speed_rpm = out_rpm_reg;

endmodule

### sv/epse_checker.sv
`timescale 1ns / 1ps
`include "encoder_position_speed_estimator_assert.svh"

module epse_checker import epse_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result beat holds
    `EPSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // one item at a time: input closes right after a beat is taken
    `EPSE_ASSERT_NEXT(a_in_close, s_tvalid && s_tready, !s_tready, "input still open after accept")

    `EPSE_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:M_USED_W] == '0, "result padding not zero")

    // rejected item reports zero position and speed
    `EPSE_ASSERT_SAME(a_bad_zero, m_tvalid && !m_tdata[0], m_tdata[M_USED_W-1:1] == '0, "rejected item with nonzero fields")

endmodule

bind encoder_position_speed_estimator epse_checker u_epse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/epse_reading_checker.sv
`timescale 1ns / 1ps

module epse_reading_checker import epse_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [1:0] kind, [3:2] motor_number, [19:4] raw_count, [51:20] now_us
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] motor_ok, [32:1] position, [64:33] speed_rpm
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    error_count,
    output int                    readings_pending
);

    typedef struct packed {
        logic        motor_ok;
        logic [31:0] position;
        logic [31:0] speed_rpm;
    } reading_t;

    reading_t expected_readings[$];
    int       mismatches = 0;

    // shadow of the register file
    logic [1:0]  rev_mask;
    logic [15:0] cpr;
    logic [15:0] min_gap;
    logic [16:0] alpha;

    // per-motor estimator state
    logic [15:0] last_raw   [MOTOR_COUNT];
    logic [31:0] pos_acc    [MOTOR_COUNT];
    logic [31:0] base_count [MOTOR_COUNT];
    logic [31:0] base_time  [MOTOR_COUNT];
    logic [31:0] rps        [MOTOR_COUNT];
    logic        primed     [MOTOR_COUNT];

    // |moved| * 1e6 * 2^16 / (dt * cpr), truncated, clamped to 0x7FFFFFFF
    function automatic logic [31:0] rate_magnitude(input longint unsigned mag,
                                                   input longint unsigned dt,
                                                   input longint unsigned cnt);
        longint unsigned num, den, ip, rem, r;
        if (dt == 0) return 32'h7FFF_FFFF;
        num = mag * 64'd1000000;
        den = dt * cnt;
        ip  = num / den;
        rem = num % den;
        if (ip >= 64'h8000) return 32'h7FFF_FFFF;
        r = (ip << 16) + ((rem << 16) / den);
        return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    function automatic logic [31:0] rpm_of(input logic [31:0] rps_q);
        longint scaled;
        scaled = longint'($signed(rps_q)) * 60;
        if (scaled > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (scaled < -64'sd2147483648) return 32'h8000_0000;
        return scaled[31:0];
    endfunction

    function automatic reading_t predict_reading(input logic [S_TDATA_W-1:0] beat);
        logic [1:0]         kind;
        logic [1:0]         motor;
        logic [15:0]        raw;
        logic [31:0]        now;
        logic [15:0]        delta16;
        logic [31:0]        delta;
        logic [31:0]        dt;
        logic signed [31:0] moved;
        logic [16:0]        a;
        longint             d, s, n, prod, sum;
        longint unsigned    mag;
        int                 m;
        reading_t           r;
        kind  = beat[1:0];
        motor = beat[3:2];
        raw   = beat[19:4];
        now   = beat[51:20];
        r = '0;
        if (motor == 0 || motor > MOTOR_COUNT || kind == KIND_RSVD) return r;
        m = motor - 1;
        r.motor_ok = 1'b1;

        if (kind == KIND_CLEAR) begin
            last_raw[m]   = raw;
            pos_acc[m]    = '0;
            base_count[m] = '0;
            base_time[m]  = '0;
            rps[m]        = '0;
            primed[m]     = 1'b0;
            return r;
        end

        delta16 = raw - last_raw[m];
        delta   = {{16{delta16[15]}}, delta16};
        if (m < 2 && rev_mask[m]) delta = -delta;
        last_raw[m] = raw;
        pos_acc[m]  = pos_acc[m] + delta;
        r.position  = pos_acc[m];
        if (kind == KIND_POS) return r;

        // first speed read after reset or clear only sets the base
        if (!primed[m]) begin
            primed[m]     = 1'b1;
            base_time[m]  = now;
            base_count[m] = pos_acc[m];
            rps[m]        = '0;
            return r;
        end

        dt    = now - base_time[m];
        moved = pos_acc[m] - base_count[m];
        d     = moved;
        if (dt >= min_gap && d != 0) begin
            base_count[m] = pos_acc[m];
            base_time[m]  = now;
            n = 0;
            if (cpr != 0) begin
                mag = (d < 0) ? -d : d;
                n   = rate_magnitude(mag, dt, cpr);
                if (d < 0) n = -n;
            end
            s    = longint'($signed(rps[m]));
            a    = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
            prod = (n - s) * longint'(a);
            sum  = s + (prod >>> 16);   // floor division by 2^16
            rps[m] = sum[31:0];
        end
        r.speed_rpm = rpm_of(rps[m]);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        reading_t got, want;
        if (!aresetn) begin
            rev_mask = RST_REVERSE_MASK;
            cpr      = RST_COUNTS_PER_REV;
            min_gap  = RST_MIN_INTERVAL;
            alpha    = RST_ALPHA;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                last_raw[i]   = '0;
                pos_acc[i]    = '0;
                base_count[i] = '0;
                base_time[i]  = '0;
                rps[i]        = '0;
                primed[i]     = 1'b0;
            end
            expected_readings.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_REVERSE_MASK:   rev_mask = cfg_wr_data[1:0];
                    CFG_COUNTS_PER_REV: cpr      = cfg_wr_data[15:0];
                    CFG_MIN_INTERVAL:   min_gap  = cfg_wr_data[15:0];
                    CFG_ALPHA:          alpha    = cfg_wr_data[16:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.motor_ok  = m_tdata[0];
                got.position  = m_tdata[32:1];
                got.speed_rpm = m_tdata[64:33];
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: ok=%0b pos=%0d rpm=%h",
                                 $time, got.motor_ok, $signed(got.position), got.speed_rpm);
                end else begin
                    want = expected_readings.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: reading mismatch: expected ok=%0b pos=%0d rpm=%h,",
                                      " got ok=%0b pos=%0d rpm=%h"}, $time,
                                     want.motor_ok, $signed(want.position), want.speed_rpm,
                                     got.motor_ok, $signed(got.position), got.speed_rpm);
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_readings.push_back(predict_reading(s_tdata));
        end
        error_count      <= mismatches;
        readings_pending <= expected_readings.size();
    end

endmodule

### bench/tb_encoder_position_speed_estimator.sv
`timescale 1ns / 1ps

module tb_encoder_position_speed_estimator;
    import epse_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 225;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // [1:0] kind, [3:2] motor_number, [19:4] raw_count, [51:20] now_us
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // [0] motor_ok, [32:1] position, [64:33] speed_rpm
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int          error_count;
    int          readings_pending;
    int          quiet_cycles = 0;
    int          ready_hold   = 0;
    logic        gaps_on      = 1'b0;
    logic [15:0] cur_gap      = RST_MIN_INTERVAL;
    logic [31:0] clock_us;
    logic [15:0] enc_raw      [MOTOR_COUNT];
    int          speed_trend  [MOTOR_COUNT];

    encoder_position_speed_estimator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    epse_reading_checker reading_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .error_count      (error_count),
        .readings_pending (readings_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure, in random bursts while gaps are on
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [1:0] motor,
                             input logic [15:0] raw, input logic [31:0] now);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'b0, now, raw, motor, kind};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off the sender until every reading is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [1:0] mask, input logic [15:0] cnt,
                                 input logic [15:0] gap_us, input logic [16:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_REVERSE_MASK;
        cfg_wr_data <= CFG_DATA_W'(mask);
        @(posedge aclk);
        cfg_addr    <= CFG_COUNTS_PER_REV;
        cfg_wr_data <= CFG_DATA_W'(cnt);
        @(posedge aclk);
        cfg_addr    <= CFG_MIN_INTERVAL;
        cfg_wr_data <= CFG_DATA_W'(gap_us);
        @(posedge aclk);
        cfg_addr    <= CFG_ALPHA;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_gap = gap_us;
    endtask

    task automatic run_phase(input int count);
        logic [1:0]  kind;
        logic [1:0]  motor;
        logic [15:0] raw;
        int          pick, idx;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) clock_us += $urandom;
            else clock_us += $urandom_range(0, 2 * cur_gap + 64);
            if (pick < 8) begin
                // noise: bad motor number or reserved kind
                kind  = 2'($urandom_range(0, 3));
                motor = 2'($urandom_range(0, 3));
                if (motor == 1 || motor == 2) kind = KIND_RSVD;
                raw = 16'($urandom);
            end else begin
                idx   = $urandom_range(0, MOTOR_COUNT - 1);
                motor = 2'(idx + 1);
                if ($urandom_range(0, 19) == 0)
                    speed_trend[idx] = int'($urandom_range(0, 1200)) - 600;
                if (pick < 16) begin
                    enc_raw[idx] = 16'($urandom);
                end else if (pick >= 24) begin
                    enc_raw[idx] += 16'(speed_trend[idx] + int'($urandom_range(0, 40)) - 20);
                end
                raw = enc_raw[idx];
                if (pick < 12) kind = KIND_CLEAR;
                else kind = ($urandom_range(0, 9) < 3) ? KIND_POS : KIND_SPEED;
            end
            send_item(kind, motor, raw, clock_us);
        end
    endtask

    initial begin
        clock_us = $urandom;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            enc_raw[i]     = 16'($urandom);
            speed_trend[i] = int'($urandom_range(0, 400)) - 200;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, extremes and the special cases
        send_item(KIND_RSVD,  2'd1, 16'h1234, 32'd10);
        send_item(KIND_SPEED, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(KIND_POS,   2'd3, 16'h0001, 32'd0);
        send_item(KIND_POS,   2'd1, 16'hFFFF, 32'd0);
        send_item(KIND_POS,   2'd2, 16'h8000, 32'd0);
        send_item(KIND_POS,   2'd2, 16'hFFFF, 32'd0);
        send_item(KIND_SPEED, 2'd1, 16'h0000, 32'd1000);
        send_item(KIND_SPEED, 2'd1, 16'hFF00, 32'd1100);
        send_item(KIND_SPEED, 2'd1, 16'hFE00, 32'd3000);
        send_item(KIND_SPEED, 2'd1, 16'hFE00, 32'd9000);
        send_item(KIND_SPEED, 2'd1, 16'hF000, 32'd9001);
        send_item(KIND_SPEED, 2'd2, 16'h0000, 32'hFFFF_FF00);
        send_item(KIND_SPEED, 2'd2, 16'h7FFF, 32'h0000_0100);
        send_item(KIND_SPEED, 2'd2, 16'hFFFE, 32'h0000_0400);
        send_item(KIND_CLEAR, 2'd2, 16'hABCD, 32'hFFFF_FFFF);
        send_item(KIND_POS,   2'd2, 16'hABCD, 32'd0);
        send_item(KIND_SPEED, 2'd2, 16'hABCE, 32'h1234_5678);
        wait_drained();
        // zero interval with movement, alpha above one
        load_settings(2'd2, 16'd1, 16'd0, 17'h1FFFF);
        send_item(KIND_SPEED, 2'd2, 16'hABD0, 32'h1234_5678);
        send_item(KIND_SPEED, 2'd1, 16'hF001, 32'h1234_5678);
        wait_drained();
        // zero counts per rev, alpha zero, widest interval
        load_settings(2'd3, 16'd0, 16'hFFFF, 17'd0);
        send_item(KIND_SPEED, 2'd1, 16'h1000, 32'h1236_0000);
        send_item(KIND_SPEED, 2'd2, 16'h2000, 32'h1236_0000);
        wait_drained();
        load_settings(2'd0, 16'hFFFF, 16'd1, ALPHA_ONE);
        send_item(KIND_SPEED, 2'd1, 16'h1005, 32'h1237_0000);
        send_item(KIND_SPEED, 2'd2, 16'h1FF0, 32'h1237_0001);
        wait_drained();

        // random phases
        gaps_on = 1'b1;
        load_settings(RST_REVERSE_MASK, RST_COUNTS_PER_REV, RST_MIN_INTERVAL, RST_ALPHA);
        run_phase(PHASE_ITEMS);
        wait_drained();
        load_settings(2'd0, 16'd1, 16'd0, ALPHA_ONE);
        run_phase(PHASE_ITEMS);
        wait_drained();
        load_settings(2'd3, 16'hFFFF, 16'hFFFF, 17'd0);
        run_phase(PHASE_ITEMS);
        wait_drained();
        gaps_on = 1'b0;
        load_settings(2'd2, 16'd0, 16'd100, 17'h1FFFF);
        run_phase(PHASE_ITEMS);
        wait_drained();
        gaps_on = 1'b1;
        load_settings(2'($urandom), 16'($urandom_range(1, 5000)),
                      16'($urandom_range(0, 2000)), 17'($urandom_range(0, 65536)));
        run_phase(PHASE_ITEMS);
        wait_drained();
        load_settings(2'd3, 16'd500, 16'd0, 17'd70000);
        run_phase(PHASE_ITEMS);
        wait_drained();
        load_settings(2'($urandom), 16'($urandom), 16'($urandom_range(0, 1000)),
                      17'($urandom_range(0, 131071)));
        run_phase(PHASE_ITEMS);
        wait_drained();
        // closing stretch at full rate
        gaps_on = 1'b0;
        load_settings(2'($urandom), 16'($urandom_range(1, 4000)),
                      16'($urandom_range(0, 500)), 17'($urandom_range(0, 65536)));
        run_phase(PHASE_ITEMS);
        wait_drained();

        repeat (50) @(posedge aclk);
        if (error_count == 0 && readings_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
